>>> rtl/lgrh_pkg.sv
package lgrh_pkg;

  localparam int SampleW = 20;
  localparam int GammaW  = 16;
  localparam int ColorW  = 16;
  localparam int Pix8W   = 8;
  localparam int CountW  = 25;
  localparam int TotalW  = 37;
  localparam int CfgW    = 60;
  localparam int DivBits = 36;

  localparam logic [19:0] One16 = 20'd65536;
  localparam logic [19:0] Sat16 = 20'd524288;
  localparam logic [21:0] AboveLim = 22'd196608;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_LEVEL_LOW  = 3'd0;
  localparam logic [2:0] CFG_LEVEL_HIGH = 3'd1;
  localparam logic [2:0] CFG_GAMMA      = 3'd2;
  localparam logic [2:0] CFG_MARK_LOW   = 3'd3;
  localparam logic [2:0] CFG_MARK_HIGH  = 3'd4;
  localparam logic [2:0] CFG_LUMA_BND   = 3'd5;
  localparam logic [2:0] CFG_MARK_COLOR = 3'd6;
  localparam logic [2:0] CFG_MARK_CTRL  = 3'd7;

  localparam logic [59:0] LevelHighRst = 60'd4503603922341888;
  localparam logic [47:0] GammaRst     = 48'd17592454483968;

  typedef enum logic [3:0] {
    S_IDLE, S_LUMA, S_MARK, S_PREP, S_DIV, S_NORM, S_LOG, S_EMUL, S_EXP,
    S_FIN, S_BLEND_A, S_BLEND_B, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LUMA, OP_MARK, OP_PREP, OP_DIV, OP_NORM, OP_LOG,
    OP_EMUL, OP_EXP, OP_FIN, OP_BLEND_A, OP_BLEND_B, OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] ch;
    logic [5:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic out_full;
  } status_t;

  typedef struct packed {
    logic [59:0] level_low;
    logic [59:0] level_high;
    logic [47:0] gamma;
    logic [59:0] mark_low;
    logic [59:0] mark_high;
    logic [39:0] luma_bounds;
    logic [47:0] mark_color;
    logic [18:0] mark_control;
  } cfg_t;

  // Q1.30 values of 2^(2^-k)
  function automatic logic [30:0] exp_tab(input logic [4:0] k);
    logic [30:0] v;
    case (k)
      5'd1:    v = 31'd1518500250;
      5'd2:    v = 31'd1276901417;
      5'd3:    v = 31'd1170923762;
      5'd4:    v = 31'd1121280436;
      5'd5:    v = 31'd1097253708;
      5'd6:    v = 31'd1085434106;
      5'd7:    v = 31'd1079572136;
      5'd8:    v = 31'd1076653033;
      5'd9:    v = 31'd1075196444;
      5'd10:   v = 31'd1074468888;
      5'd11:   v = 31'd1074105294;
      5'd12:   v = 31'd1073923544;
      5'd13:   v = 31'd1073832680;
      5'd14:   v = 31'd1073787251;
      5'd15:   v = 31'd1073764537;
      5'd16:   v = 31'd1073753181;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] luma_coef(input logic [1:0] ch);
    logic [15:0] v;
    case (ch)
      2'd0:    v = 16'd19595;
      2'd1:    v = 16'd38470;
      default: v = 16'd7471;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/lgrh_ctrl.sv
module lgrh_ctrl import lgrh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic [5:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= 2'd0;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LUMA;
          ch_d    = 2'd0;
        end
      end
      S_LUMA: begin
        if (ch_q == 2'd2) begin
          state_d = S_MARK;
          ch_d    = 2'd0;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      S_MARK: state_d = S_PREP;
      S_PREP: begin
        if (status_i.special) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DIV;
          cnt_d   = 6'(DivBits - 1);
        end
      end
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          state_d = S_NORM;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      S_NORM: begin
        state_d = S_LOG;
        cnt_d   = 6'd15;
      end
      S_LOG: begin
        if (cnt_q == 6'd0) begin
          state_d = S_EMUL;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      S_EMUL: begin
        state_d = S_EXP;
        cnt_d   = 6'd1;
      end
      S_EXP: begin
        if (cnt_q == 6'd16) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_FIN: begin
        if (ch_q == 2'd2) begin
          state_d = S_BLEND_A;
          ch_d    = 2'd0;
        end else begin
          state_d = S_PREP;
          ch_d    = ch_q + 2'd1;
        end
      end
      S_BLEND_A: state_d = S_BLEND_B;
      S_BLEND_B: begin
        if (ch_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          state_d = S_BLEND_A;
          ch_d    = ch_q + 2'd1;
        end
      end
      S_OUT: begin
        if (!status_i.out_full) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.ch   = ch_q;
    cmd_o.cnt  = cnt_q;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE:    cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_LUMA:    cmd_o.op = OP_LUMA;
      S_MARK:    cmd_o.op = OP_MARK;
      S_PREP:    cmd_o.op = OP_PREP;
      S_DIV:     cmd_o.op = OP_DIV;
      S_NORM:    cmd_o.op = OP_NORM;
      S_LOG:     cmd_o.op = OP_LOG;
      S_EMUL:    cmd_o.op = OP_EMUL;
      S_EXP:     cmd_o.op = OP_EXP;
      S_FIN:     cmd_o.op = OP_FIN;
      S_BLEND_A: cmd_o.op = OP_BLEND_A;
      S_BLEND_B: cmd_o.op = OP_BLEND_B;
      S_OUT:     cmd_o.op = status_i.out_full ? OP_NONE : OP_OUT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/lgrh_dp.sv
module lgrh_dp import lgrh_pkg::*; #(
  parameter int MAX_FRAME_PIXELS = 16777216,
  parameter int SAMPLE_FRAC_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  cfg_t              cfg_i,
  output status_t           status_o,
  input  logic [SampleW-1:0] red_in_i,
  input  logic [SampleW-1:0] green_in_i,
  input  logic [SampleW-1:0] blue_in_i,
  input  logic              last_pixel_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [Pix8W-1:0]  red_out_o,
  output logic [Pix8W-1:0]  green_out_o,
  output logic [Pix8W-1:0]  blue_out_o,
  output logic              marked_o,
  output logic              frame_done_o,
  output logic [CountW-1:0] below_total_o,
  output logic [CountW-1:0] above_total_o,
  output logic [TotalW-1:0] red_total_o,
  output logic [TotalW-1:0] green_total_o,
  output logic [TotalW-1:0] blue_total_o
);

  localparam int CntW     = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int AccW     = CntW + SAMPLE_FRAC_BITS;
  localparam int AccShift = 16 - SAMPLE_FRAC_BITS;
  localparam logic [CntW-1:0] CntLim = CntW'(MAX_FRAME_PIXELS);
  localparam logic [AccW-1:0] AccLim = AccW'(MAX_FRAME_PIXELS) << SAMPLE_FRAC_BITS;

  // pixel and marking
  logic [SampleW-1:0] pix_q [3];
  logic               last_q;
  logic [36:0]        luma_acc_q;
  logic               mark_q;

  // shared power unit
  logic               special_q;
  logic [19:0]        spec_val_q;
  logic [19:0]        ar_q;
  logic [35:0]        num_q;
  logic [35:0]        quo_q;
  logic [19:0]        rem_q;
  logic               found_q;
  logic [5:0]         msb_q;
  logic [30:0]        mant_q;
  logic [15:0]        frac_q;
  logic signed [26:0] e_q;
  logic [31:0]        mexp_q;
  logic [19:0]        pow_q [3];
  logic [31:0]        bl_q;
  logic [Pix8W-1:0]   pix8_q [3];

  // statistics and output register
  logic [CntW-1:0]    below_q, above_q;
  logic [AccW-1:0]    acc_q [3];
  logic               out_valid_q;
  logic [Pix8W-1:0]   red_out_q, green_out_q, blue_out_q;
  logic               marked_q, frame_done_q;
  logic [CountW-1:0]  below_out_q, above_out_q;
  logic [TotalW-1:0]  tot_out_q [3];

  function automatic logic [16:0] clamp1(input logic [19:0] v);
    return (v > One16) ? 17'd65536 : v[16:0];
  endfunction

  // channel selects
  logic [SampleW-1:0] sel_pix, sel_lo, sel_hi;
  logic [GammaW-1:0]  sel_g;
  logic [ColorW-1:0]  sel_mc;
  logic [15:0]        weight;

  assign sel_pix = pix_q[cmd_i.ch];
  assign sel_lo  = cfg_i.level_low[SampleW*cmd_i.ch +: SampleW];
  assign sel_hi  = cfg_i.level_high[SampleW*cmd_i.ch +: SampleW];
  assign sel_g   = cfg_i.gamma[GammaW*cmd_i.ch +: GammaW];
  assign sel_mc  = cfg_i.mark_color[ColorW*cmd_i.ch +: ColorW];
  assign weight  = cfg_i.mark_control[18:3];

  // levels setup
  logic [20:0] diff, rng;
  logic        d_neg, r_neg, d_zero, r_zero, opp, prep_special;
  logic [19:0] ad, arg;
  assign diff   = {1'b0, sel_pix} - {1'b0, sel_lo};
  assign rng    = {1'b0, sel_hi} - {1'b0, sel_lo};
  assign d_neg  = diff[20];
  assign r_neg  = rng[20];
  assign d_zero = (diff == 21'd0);
  assign r_zero = (rng == 21'd0);
  assign ad     = d_neg ? 20'(-diff) : diff[19:0];
  assign arg    = r_neg ? 20'(-rng) : rng[19:0];
  assign opp    = (d_neg && !r_zero && !r_neg) || (!d_neg && !d_zero && r_neg);
  assign prep_special = r_zero || opp || (sel_g == '0);

  // restoring divide step
  logic [20:0] trial;
  logic        q_bit;
  logic [19:0] rem_nx;
  assign trial  = {rem_q, num_q[35]};
  assign q_bit  = (trial >= {1'b0, ar_q});
  assign rem_nx = q_bit ? 20'(trial - {1'b0, ar_q}) : trial[19:0];

  // normalize, square, log/gamma product
  logic [65:0]        norm_sh;
  logic [61:0]        sq;
  logic [31:0]        sq_t;
  logic signed [6:0]  mm16;
  logic signed [22:0] logv;
  logic signed [39:0] eprod;
  assign norm_sh = {quo_q, 30'd0} >> msb_q;
  assign sq      = mant_q * mant_q;
  assign sq_t    = sq[61:30];
  assign mm16    = $signed({1'b0, msb_q}) - 7'sd16;
  assign logv    = $signed({mm16, frac_q});
  assign eprod   = $signed({1'b0, sel_g}) * logv;

  // exponent step and final scaling
  logic [3:0]         ebit_idx;
  logic [62:0]        mprod;
  logic signed [10:0] ip;
  logic signed [11:0] sh;
  logic [31:0]        mshift;
  logic [19:0]        fin_val;
  assign ebit_idx = 4'(5'd16 - cmd_i.cnt[4:0]);
  assign mprod    = mexp_q * exp_tab(cmd_i.cnt[4:0]);
  assign ip       = e_q[26:16];
  assign sh       = 12'sd14 - 12'(ip);
  assign mshift   = mexp_q >> sh[4:0];

  always_comb begin
    if (special_q) begin
      fin_val = spec_val_q;
    end else if (!found_q) begin
      fin_val = 20'd0;
    end else if (ip >= 11'sd3) begin
      fin_val = Sat16;
    end else if (sh > 12'sd31) begin
      fin_val = 20'd0;
    end else begin
      fin_val = mshift[19:0];
    end
  end

  // marking test
  logic [19:0] luma;
  logic        all_in, all_lo, all_hi, mark_nx;
  assign luma = luma_acc_q[35:16];
  always_comb begin
    all_in = 1'b1;
    all_lo = 1'b1;
    all_hi = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!(pix_q[i] >= cfg_i.mark_low[SampleW*i +: SampleW] &&
            pix_q[i] < cfg_i.mark_high[SampleW*i +: SampleW])) all_in = 1'b0;
      if (!(pix_q[i] < cfg_i.mark_low[SampleW*i +: SampleW])) all_lo = 1'b0;
      if (!(pix_q[i] >= cfg_i.mark_high[SampleW*i +: SampleW])) all_hi = 1'b0;
    end
    if (!cfg_i.mark_control[0]) begin
      mark_nx = 1'b0;
    end else if (cfg_i.mark_control[1]) begin
      mark_nx = cfg_i.mark_control[2] ? all_in : (all_lo || all_hi);
    end else if (cfg_i.mark_control[2]) begin
      mark_nx = (luma >= cfg_i.luma_bounds[19:0]) && (luma < cfg_i.luma_bounds[39:20]);
    end else begin
      mark_nx = (luma < cfg_i.luma_bounds[19:0]) || (luma >= cfg_i.luma_bounds[39:20]);
    end
  end

  // blend and quantize
  logic [16:0] cl_sel, wc, vb, vsel, vm1;
  logic [33:0] bsum;
  assign cl_sel = clamp1(pow_q[cmd_i.ch]);
  assign wc     = 17'd65536 - {1'b0, weight};
  assign bsum   = {2'b0, bl_q} + wc * cl_sel;
  assign vb     = bsum[32:16];
  assign vsel   = mark_q ? vb : cl_sel;
  assign vm1    = vsel - 17'd1;

  // statistics
  logic [21:0]     psum;
  logic            is_below, is_above;
  logic [CntW-1:0] below_nx, above_nx;
  logic [AccW-1:0] acc_nx [3];
  logic [AccW:0]   acc_sum [3];
  assign psum     = {2'b0, pow_q[0]} + {2'b0, pow_q[1]} + {2'b0, pow_q[2]};
  assign is_below = (psum == 22'd0);
  assign is_above = !is_below && (psum > AboveLim);
  assign below_nx = (is_below && below_q != CntLim) ? below_q + 1'b1 : below_q;
  assign above_nx = (is_above && above_q != CntLim) ? above_q + 1'b1 : above_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_sum[i] = {1'b0, acc_q[i]} + (AccW+1)'(clamp1(pow_q[i]) >> AccShift);
      acc_nx[i]  = (acc_sum[i] > {1'b0, AccLim}) ? AccLim : acc_sum[i][AccW-1:0];
    end
  end

  logic [CntW+CountW-1:0] below_ext, above_ext;
  logic [AccW+TotalW-1:0] acc_ext [3];
  assign below_ext = {{CountW{1'b0}}, below_nx};
  assign above_ext = {{CountW{1'b0}}, above_nx};
  always_comb begin
    for (int i = 0; i < 3; i++) acc_ext[i] = {{TotalW{1'b0}}, acc_nx[i]};
  end

  assign status_o.special  = prep_special;
  assign status_o.out_full = out_valid_q && out_stall_i;

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        pix_q[0] <= red_in_i;
        pix_q[1] <= green_in_i;
        pix_q[2] <= blue_in_i;
        last_q   <= last_pixel_i;
      end
      OP_LUMA: begin
        luma_acc_q <= (cmd_i.ch == 2'd0 ? 37'd0 : luma_acc_q) +
                      37'(luma_coef(cmd_i.ch)) * 37'(sel_pix);
      end
      OP_MARK: mark_q <= mark_nx;
      OP_PREP: begin
        special_q  <= prep_special;
        spec_val_q <= (r_zero || opp) ? 20'd0 : One16;
        ar_q       <= arg;
        num_q      <= {ad, 16'd0};
        quo_q      <= '0;
        rem_q      <= '0;
        found_q    <= 1'b0;
        msb_q      <= '0;
      end
      OP_DIV: begin
        rem_q <= rem_nx;
        num_q <= {num_q[34:0], 1'b0};
        quo_q <= {quo_q[34:0], q_bit};
        if (q_bit && !found_q) begin
          found_q <= 1'b1;
          msb_q   <= cmd_i.cnt;
        end
      end
      OP_NORM: begin
        mant_q <= norm_sh[30:0];
        frac_q <= '0;
      end
      OP_LOG: begin
        if (sq_t[31]) begin
          frac_q[cmd_i.cnt[3:0]] <= 1'b1;
          mant_q <= sq_t[31:1];
        end else begin
          mant_q <= sq_t[30:0];
        end
      end
      OP_EMUL: begin
        e_q    <= 27'(eprod >>> 12);
        mexp_q <= 32'd1 << 30;
      end
      OP_EXP: begin
        if (e_q[ebit_idx]) mexp_q <= mprod[61:30];
      end
      OP_FIN: pow_q[cmd_i.ch] <= fin_val;
      OP_BLEND_A: bl_q <= weight * sel_mc;
      OP_BLEND_B: pix8_q[cmd_i.ch] <= (vsel == 17'd0) ? 8'd0 : vm1[15:8];
      OP_OUT: begin
        red_out_q    <= pix8_q[0];
        green_out_q  <= pix8_q[1];
        blue_out_q   <= pix8_q[2];
        marked_q     <= mark_q;
        frame_done_q <= last_q;
        below_out_q  <= last_q ? below_ext[CountW-1:0] : '0;
        above_out_q  <= last_q ? above_ext[CountW-1:0] : '0;
        for (int i = 0; i < 3; i++) begin
          tot_out_q[i] <= last_q ? acc_ext[i][TotalW-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  // control and statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      below_q     <= '0;
      above_q     <= '0;
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
    end else begin
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
        below_q     <= last_q ? '0 : below_nx;
        above_q     <= last_q ? '0 : above_nx;
        for (int i = 0; i < 3; i++) acc_q[i] <= last_q ? '0 : acc_nx[i];
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_out_o     = red_out_q;
  assign green_out_o   = green_out_q;
  assign blue_out_o    = blue_out_q;
  assign marked_o      = marked_q;
  assign frame_done_o  = frame_done_q;
  assign below_total_o = below_out_q;
  assign above_total_o = above_out_q;
  assign red_total_o   = tot_out_q[0];
  assign green_total_o = tot_out_q[1];
  assign blue_total_o  = tot_out_q[2];

endmodule

>>> rtl/levels_gamma_range_highlight_top.sv
// Levels, gamma and range marking for one Q8.12 RGB pixel per transfer.
// Each channel is normalized by its black and white level and raised to its
// gamma through one shared log2/exp2 unit, the pixel is tested against the
// marking bounds (per channel or by luma, inside or outside) and blended
// toward the mark colour, and an 8-bit RGB result is produced. The pixel
// flagged last carries the frame statistics (this pixel included) and clears
// them. One pixel is in work at a time: accept, a luma step per channel,
// a mark step, then per channel a setup step, 36 restoring divide steps,
// a normalize step, 16 squaring steps, a gamma multiply, 16 exp2 steps and
// a finish step, or only setup and finish for a zero range, a value and
// range of opposite sign or zero gamma, then the blend steps for each
// channel and the output load. The output register lets the next pixel
// start while a result still waits to be taken. Configuration writes take
// effect at once and are to be made only while the block is idle; the
// block itself does not enforce this.
module levels_gamma_range_highlight_top import lgrh_pkg::*; #(
  parameter int MAX_FRAME_PIXELS = 16777216,
  parameter int SAMPLE_FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] red_in_i,
  input  logic [SampleW-1:0] green_in_i,
  input  logic [SampleW-1:0] blue_in_i,
  input  logic               last_pixel_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [Pix8W-1:0]   red_out_o,
  output logic [Pix8W-1:0]   green_out_o,
  output logic [Pix8W-1:0]   blue_out_o,
  output logic               marked_o,
  output logic               frame_done_o,
  output logic [CountW-1:0]  below_total_o,
  output logic [CountW-1:0]  above_total_o,
  output logic [TotalW-1:0]  red_total_o,
  output logic [TotalW-1:0]  green_total_o,
  output logic [TotalW-1:0]  blue_total_o
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  // Configuration registers; each write is truncated to its register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_low    <= '0;
      cfg_q.level_high   <= LevelHighRst;
      cfg_q.gamma        <= GammaRst;
      cfg_q.mark_low     <= '0;
      cfg_q.mark_high    <= '0;
      cfg_q.luma_bounds  <= '0;
      cfg_q.mark_color   <= '0;
      cfg_q.mark_control <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LEVEL_LOW:  cfg_q.level_low    <= cfg_wdata_i[59:0];
        CFG_LEVEL_HIGH: cfg_q.level_high   <= cfg_wdata_i[59:0];
        CFG_GAMMA:      cfg_q.gamma        <= cfg_wdata_i[47:0];
        CFG_MARK_LOW:   cfg_q.mark_low     <= cfg_wdata_i[59:0];
        CFG_MARK_HIGH:  cfg_q.mark_high    <= cfg_wdata_i[59:0];
        CFG_LUMA_BND:   cfg_q.luma_bounds  <= cfg_wdata_i[39:0];
        CFG_MARK_COLOR: cfg_q.mark_color   <= cfg_wdata_i[47:0];
        CFG_MARK_CTRL:  cfg_q.mark_control <= cfg_wdata_i[18:0];
        default: ;
      endcase
    end
  end

  // Sequencer: walks the pixel through luma, marking, the three channel
  // powers, blending and the output load
  lgrh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: shared divider / log2 / exp2 unit, marking, statistics and
  // the output register
  lgrh_dp #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .status_o      (status),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .last_pixel_i  (last_pixel_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .marked_o      (marked_o),
    .frame_done_o  (frame_done_o),
    .below_total_o (below_total_o),
    .above_total_o (above_total_o),
    .red_total_o   (red_total_o),
    .green_total_o (green_total_o),
    .blue_total_o  (blue_total_o)
  );

`ifndef SYNTHESIS
  // A transfer in starts work, so the next cycle holds off input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off after a transfer");

  // A result appears only from the output load step
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.op == OP_OUT))
    else $error("result appeared without an output load");

  // Statistics fields are zero on results that do not end a frame
  a_stats_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> below_total_o == '0 && above_total_o == '0
      && red_total_o == '0 && green_total_o == '0 && blue_total_o == '0)
    else $error("statistics present on a result that does not end a frame");
`endif

endmodule
